// File: src/srte_pkg.sv
// ----------------------------------------------------------------------------
// srte_pkg: shared types and constants of the stitch record ternary encoder
// Sequencer states, digit step codes, record flag bytes and the helper
// functions for clamping, division by five and digit bit placement.
// ----------------------------------------------------------------------------
package srte_pkg;

  // Axis limits of one record (+/-121 with five balanced ternary digits)
  localparam logic signed [7:0] AXIS_MAX = 8'sd121;
  localparam logic signed [7:0] AXIS_MIN = -8'sd121;

  // Trim split and digit count
  localparam int TRIM_PARTS = 5;
  localparam int DIGITS     = 5;

  // Reciprocal of five scaled by 2^10, exact for magnitudes up to 121
  localparam int DIV5_RECIP = 205;
  localparam int DIV5_SHIFT = 10;

  // Flag bytes ORed into byte two; END_BYTE replaces byte two instead
  localparam logic [7:0] FLAG_SET  = 8'h03;
  localparam logic [7:0] FLAG_JUMP = 8'h83;
  localparam logic [7:0] FLAG_STOP = 8'hC3;
  localparam logic [7:0] END_BYTE  = 8'h8D;

  // Digit step codes, most significant digit first
  localparam logic [2:0] STEP_81 = 3'd0;
  localparam logic [2:0] STEP_27 = 3'd1;
  localparam logic [2:0] STEP_9  = 3'd2;
  localparam logic [2:0] STEP_3  = 3'd3;
  localparam logic [2:0] STEP_1  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIGIT,
    S_OUT
  } srte_state_t;

  // Result of one digit step on one axis
  typedef struct packed {
    logic              pos;
    logic              neg;
    logic signed [7:0] res;
  } srte_trit_t;

  // Digit weight of a step
  function automatic logic signed [7:0] trit_weight(input logic [2:0] step);
    logic signed [7:0] w;
    unique case (step)
      STEP_81: w = 8'sd81;
      STEP_27: w = 8'sd27;
      STEP_9:  w = 8'sd9;
      STEP_3:  w = 8'sd3;
      STEP_1:  w = 8'sd1;
      default: w = 8'sd0;
    endcase
    return w;
  endfunction

  // Decision threshold of a step: half the weight, rounded down
  function automatic logic signed [7:0] trit_thresh(input logic [2:0] step);
    logic signed [7:0] t;
    unique case (step)
      STEP_81: t = 8'sd40;
      STEP_27: t = 8'sd13;
      STEP_9:  t = 8'sd4;
      STEP_3:  t = 8'sd1;
      STEP_1:  t = 8'sd0;
      default: t = AXIS_MAX;
    endcase
    return t;
  endfunction

  // Saturate one axis to the record range
  function automatic logic signed [7:0] clamp_axis(input logic signed [7:0] v);
    logic signed [7:0] r;
    if (v > AXIS_MAX) begin
      r = AXIS_MAX;
    end else if (v < AXIS_MIN) begin
      r = AXIS_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic axis_clipped(input logic signed [7:0] v);
    return (v > AXIS_MAX) || (v < AXIS_MIN);
  endfunction

  // Division by five, truncated toward zero, for |v| <= 121
  function automatic logic signed [5:0] div5(input logic signed [7:0] v);
    logic [7:0]  mag;
    logic [14:0] prod;
    logic [5:0]  q;
    mag  = v[7] ? 8'(-v) : 8'(v);
    prod = 15'(mag[6:0]) * 15'(DIV5_RECIP);
    q    = {1'b0, prod[14:DIV5_SHIFT]};
    return v[7] ? $signed(6'(-q)) : $signed(q);
  endfunction

  // Place the digit bits of one step into the 24-bit record {b2, b1, b0}
  function automatic logic [23:0] trit_mask(input logic [2:0] step,
                                            input srte_trit_t tx,
                                            input srte_trit_t ty);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = '0;
    b1 = '0;
    b2 = '0;
    unique case (step)
      STEP_81: b2 = {2'b00, ty.pos, ty.neg, tx.neg, tx.pos, 2'b00};
      STEP_27: b1 = {2'b00, ty.pos, ty.neg, tx.neg, tx.pos, 2'b00};
      STEP_9:  b0 = {2'b00, ty.pos, ty.neg, tx.neg, tx.pos, 2'b00};
      STEP_3:  b1 = {ty.pos, ty.neg, 4'b0000, tx.neg, tx.pos};
      STEP_1:  b0 = {ty.pos, ty.neg, 4'b0000, tx.neg, tx.pos};
      default: b0 = '0;
    endcase
    return {b2, b1, b0};
  endfunction

endpackage

// File: src/srte_if.sv
// ----------------------------------------------------------------------------
// srte_if: request channels of the stitch record ternary encoder
// srte_in_if carries one stitch move, srte_out_if one 3-byte record.
// ----------------------------------------------------------------------------
interface srte_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic              is_jump;
  logic              is_stop;
  logic              is_trim;
  logic              is_end;

  modport source (output valid, dx, dy, is_jump, is_stop, is_trim, is_end,
                  input ready);
  modport sink (input valid, dx, dy, is_jump, is_stop, is_trim, is_end,
                output ready);
endinterface

interface srte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_zero;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic       last_record;
  logic       clipped;

  modport source (output valid, byte_zero, byte_one, byte_two, last_record,
                  clipped, input ready);
  modport sink (input valid, byte_zero, byte_one, byte_two, last_record,
                clipped, output ready);
endinterface

// File: src/stitch_record_ternary_encoder_unit.sv
// ----------------------------------------------------------------------------
// stitch_record_ternary_encoder_unit: stitch move to 3-byte record encoder
// Saturates the move, splits trims into five jumps and encodes both axes
// in balanced ternary one digit per cycle on a shared digit step unit.
// ----------------------------------------------------------------------------
// Sequence: an accepted move passes one setup state (S_PREP); each record is then
//   built in digit steps (S_DIGIT) and held in the output state until taken.
// Flow: a new move is taken only in idle, after its last record is taken;
//   each record takes five passes through the digit step unit.
// Reset: rst (synchronous) returns the sequencer to idle, no record pending.
module stitch_record_ternary_encoder_unit (
  input  logic             clk,
  input  logic             rst,
  srte_in_if.sink          moves,
  srte_out_if.source       records
);
  import srte_pkg::*;

  srte_state_t       state;
  srte_state_t       state_next;

  logic [2:0]        step;
  logic [2:0]        part;

  logic signed [7:0] cx;
  logic signed [7:0] cy;
  logic signed [5:0] px;
  logic signed [5:0] py;
  logic              clip;
  logic              f_jump;
  logic              f_stop;
  logic              f_trim;
  logic              f_end;
  logic signed [7:0] rx;
  logic signed [7:0] ry;
  logic [23:0]       rec;

  logic              load_move;
  logic              rec_done;
  logic              last;
  logic              digit_end;
  logic signed [7:0] px_ext;
  logic signed [7:0] py_ext;
  logic signed [7:0] rem_x;
  logic signed [7:0] rem_y;
  srte_trit_t        tx;
  srte_trit_t        ty;

  // Shared digit step unit, one lane per axis
  srte_trit_step u_step_x (.res(rx), .step(step), .trit(tx));
  srte_trit_step u_step_y (.res(ry), .step(step), .trit(ty));

  // Handshake and sequencing conditions
  always_comb begin
    moves.ready   = state == S_IDLE;
    records.valid = state == S_OUT;
    load_move     = moves.valid && moves.ready;
    rec_done      = records.valid && records.ready;
    last          = !f_trim || (part == 3'(TRIM_PARTS - 1));
    digit_end     = step == 3'(DIGITS - 1);
  end

  // Trim part and remainder of the last trim record
  assign px_ext = 8'(px);
  assign py_ext = 8'(py);
  assign rem_x  = cx - (px_ext <<< 2);
  assign rem_y  = cy - (py_ext <<< 2);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (load_move) state_next = S_PREP;
      S_PREP:  state_next = S_DIGIT;
      S_DIGIT: if (digit_end) state_next = S_OUT;
      S_OUT: begin
        if (rec_done) state_next = last ? S_IDLE : S_DIGIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      part  <= '0;
    end else begin
      state <= state_next;
      priority case (state)
        S_PREP: begin
          step <= '0;
          part <= '0;
        end
        S_DIGIT: step <= step + 3'd1;
        S_OUT: begin
          if (rec_done && !last) begin
            step <= '0;
            part <= part + 3'd1;
          end
        end
        default: step <= step;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_move) begin
      cx     <= clamp_axis(moves.dx);
      cy     <= clamp_axis(moves.dy);
      clip   <= axis_clipped(moves.dx) || axis_clipped(moves.dy);
      f_jump <= moves.is_jump;
      f_stop <= moves.is_stop;
      f_trim <= moves.is_trim;
      f_end  <= moves.is_end;
    end
    priority case (state)
      S_PREP: begin
        px  <= div5(cx);
        py  <= div5(cy);
        rx  <= f_trim ? 8'(div5(cx)) : cx;
        ry  <= f_trim ? 8'(div5(cy)) : cy;
        rec <= '0;
      end
      S_DIGIT: begin
        rx  <= tx.res;
        ry  <= ty.res;
        rec <= rec | trit_mask(step, tx, ty);
      end
      S_OUT: begin
        if (rec_done && !last) begin
          rx  <= (part == 3'(TRIM_PARTS - 2)) ? rem_x : px_ext;
          ry  <= (part == 3'(TRIM_PARTS - 2)) ? rem_y : py_ext;
          rec <= '0;
        end
      end
      default: rec <= rec;
    endcase
  end

  // Record bytes with flag overlay; trim records are plain jumps
  always_comb begin
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = rec[7:0];
    b1 = rec[15:8];
    b2 = rec[23:16] | FLAG_SET;
    if (f_end && !f_trim) begin
      b0 = '0;
      b1 = '0;
      b2 = END_BYTE;
    end
    if (f_jump || f_trim) b2 = b2 | FLAG_JUMP;
    if (f_stop && !f_trim) b2 = b2 | FLAG_STOP;
    records.byte_zero   = b0;
    records.byte_one    = b1;
    records.byte_two    = b2;
    records.last_record = last;
    records.clipped     = clip;
  end

`ifndef SYNTHESIS
  // A move is never taken while a record is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(moves.ready && records.valid))
    else $error("move accepted while a record is pending");

  // Every trim record is a jump without the stop bit
  a_trim_jump: assert property (@(posedge clk) disable iff (rst)
    (records.valid && f_trim) |-> (records.byte_two[7:6] == 2'b10))
    else $error("trim record not marked as plain jump");

  // Digit counter stays within the five digits while stepping
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (step <= 3'(DIGITS - 1)))
    else $error("digit step counter out of range");

  // A record appears exactly after the last digit step
  a_out_after_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && digit_end) |=> records.valid)
    else $error("record not presented after the last digit");
`endif

endmodule

// File: src/srte_trit_step.sv
// ----------------------------------------------------------------------------
// srte_trit_step: one balanced ternary digit step
// Compares the residual against half the digit weight, picks the digit
// (+1, -1 or 0) and returns the residual with that digit removed.
// ----------------------------------------------------------------------------
module srte_trit_step (
  input  logic signed [7:0]   res,
  input  logic [2:0]          step,
  output srte_pkg::srte_trit_t trit
);
  import srte_pkg::*;

  logic signed [7:0] weight;
  logic signed [7:0] thresh;

  // Weight and threshold of the current digit
  assign weight = trit_weight(step);
  assign thresh = trit_thresh(step);

  // Digit decision and residual update
  always_comb begin
    trit.pos = res > thresh;
    trit.neg = res < -thresh;
    if (trit.pos) begin
      trit.res = res - weight;
    end else if (trit.neg) begin
      trit.res = res + weight;
    end else begin
      trit.res = res;
    end
  end

endmodule
